### hdl/icy_metadata_deframer_unit_defines.svh
`ifndef ICY_METADATA_DEFRAMER_UNIT_DEFINES_SVH
`define ICY_METADATA_DEFRAMER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define IMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define IMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/icy_mdf_pkg.sv
package icy_mdf_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int CMP_W       = 32;
  localparam int INTERVAL_W  = 24;
  localparam int REMAIN_W    = 12;
  localparam int KEY_LEN     = 13;
  localparam int MATCH_W     = 4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [7:0] TERM_CHAR = 8'h3B;

  localparam logic [7:0] TITLE_KEY [0:KEY_LEN-1] = '{
    8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6D, 8'h54,
    8'h69, 8'h74, 8'h6C, 8'h65, 8'h3D, 8'h27
  };

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_DROP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_META  = 2'd2
  } phase_t;

  typedef enum logic {
    REG_META_INTERVAL = 1'b0,
    REG_TITLE_ENABLE  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] meta_interval;
    logic                  title_enable;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    kind_t      kind;
    logic [7:0] data;
  } res_t;

endpackage

### hdl/icy_mdf_byte_if.sv
interface icy_mdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### hdl/icy_mdf_result_if.sv
interface icy_mdf_result_if import icy_mdf_pkg::*;;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] out_byte;

  modport source (output valid, output kind, output out_byte, input ready);
  modport sink (input valid, input kind, input out_byte, output ready);
endinterface

### hdl/icy_mdf_cfg_if.sv
interface icy_mdf_cfg_if import icy_mdf_pkg::*;;
  logic                  valid;
  logic                  ready;
  reg_index_t            index;
  logic [INTERVAL_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/icy_mdf_cfg.sv
module icy_mdf_cfg import icy_mdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  icy_mdf_cfg_if.sink      cfg,
  output cfg_t             regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.meta_interval <= '0;
      regs.title_enable  <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_META_INTERVAL: regs.meta_interval <= cfg.data;
        REG_TITLE_ENABLE:  regs.title_enable  <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/icy_mdf_core.sv
module icy_mdf_core import icy_mdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  `include "icy_metadata_deframer_unit_defines.svh"

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] audio_count, audio_count_next;
  logic [REMAIN_W-1:0]    meta_remaining, meta_remaining_next;
  logic [MATCH_W-1:0]     match_pos, match_pos_next;
  logic                   in_title, in_title_next;
  logic                   title_seen, title_seen_next;
  logic [7:0]             held_byte, held_byte_next;
  logic                   held_valid, held_valid_next;

  logic                   take_len;
  logic                   interval_hit;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [REMAIN_W-1:0]    rem_dec;
  logic [REMAIN_W-1:0]    len_blocks;
  logic                   last;
  logic                   key_ok;
  logic [MATCH_W-1:0]     match_step;

  assign interval_hit = CMP_W'(audio_count) >= CMP_W'(cfg.meta_interval);
  assign count_inc    = (audio_count == COUNT_MAX) ? audio_count
                                                   : audio_count + COUNT_WIDTH'(1);
  assign rem_dec      = (meta_remaining != '0) ? meta_remaining - REMAIN_W'(1)
                                               : meta_remaining;
  assign last         = (rem_dec == '0);
  assign len_blocks   = {data_byte, 4'b0000};
  assign key_ok       = (match_pos < MATCH_W'(KEY_LEN)) &&
                        (data_byte == TITLE_KEY[match_pos]);

  always_comb begin
    phase_next          = phase;
    audio_count_next    = audio_count;
    meta_remaining_next = meta_remaining;
    match_pos_next      = match_pos;
    in_title_next       = in_title;
    title_seen_next     = title_seen;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    res                 = '{hit: 1'b0, kind: KIND_AUDIO, data: 8'h00};
    take_len            = 1'b0;
    match_step          = '0;

    case (phase)
      PH_LEN: begin
        take_len = 1'b1;
      end
      PH_META: begin
        meta_remaining_next = rem_dec;
        if (last) begin
          phase_next = PH_AUDIO;
        end
        if (cfg.title_enable) begin
          if (in_title) begin
            if (data_byte == TERM_CHAR) begin
              in_title_next   = 1'b0;
              held_valid_next = 1'b0;
              res             = '{hit: 1'b1, kind: KIND_DONE, data: 8'h00};
            end else if (data_byte == 8'h00 || last) begin
              in_title_next   = 1'b0;
              held_valid_next = 1'b0;
              res             = '{hit: 1'b1, kind: KIND_DROP, data: 8'h00};
            end else begin
              if (held_valid) begin
                res = '{hit: 1'b1, kind: KIND_TITLE, data: held_byte};
              end
              held_byte_next  = data_byte;
              held_valid_next = 1'b1;
            end
          end else if (!title_seen) begin
            if (key_ok) begin
              match_step = match_pos + MATCH_W'(1);
            end else begin
              match_step = (data_byte == TITLE_KEY[0]) ? MATCH_W'(1) : '0;
            end
            match_pos_next = match_step;
            if (match_step >= MATCH_W'(KEY_LEN)) begin
              match_pos_next  = '0;
              title_seen_next = 1'b1;
              if (!last) begin
                in_title_next   = 1'b1;
                held_valid_next = 1'b0;
                held_byte_next  = 8'h00;
              end
            end
          end
        end
      end
      default: begin
        phase_next = PH_AUDIO;
        if (cfg.meta_interval == '0) begin
          res = '{hit: 1'b1, kind: KIND_AUDIO, data: data_byte};
        end else if (interval_hit) begin
          audio_count_next = '0;
          take_len         = 1'b1;
        end else begin
          res = '{hit: 1'b1, kind: KIND_AUDIO, data: data_byte};
          if (CMP_W'(count_inc) >= CMP_W'(cfg.meta_interval)) begin
            audio_count_next = '0;
            phase_next       = PH_LEN;
          end else begin
            audio_count_next = count_inc;
          end
        end
      end
    endcase

    if (take_len) begin
      meta_remaining_next = len_blocks;
      phase_next          = (len_blocks == '0) ? PH_AUDIO : PH_META;
      match_pos_next      = '0;
      in_title_next       = 1'b0;
      title_seen_next     = 1'b0;
      held_byte_next      = 8'h00;
      held_valid_next     = 1'b0;
    end

    if (!step) begin
      res.hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_AUDIO;
      audio_count    <= '0;
      meta_remaining <= '0;
      match_pos      <= '0;
      in_title       <= 1'b0;
      title_seen     <= 1'b0;
      held_byte      <= 8'h00;
      held_valid     <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      audio_count    <= audio_count_next;
      meta_remaining <= meta_remaining_next;
      match_pos      <= match_pos_next;
      in_title       <= in_title_next;
      title_seen     <= title_seen_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
    end
  end

  `IMD_ASSERT(a_held_needs_title, !in_title |-> !held_valid, "held byte outside a title")
  `IMD_ASSERT(a_title_after_key, in_title |-> title_seen, "title open without key match")
  `IMD_ASSERT(a_meta_not_empty, (phase == PH_META) |-> (meta_remaining != '0),
              "metadata phase with no bytes left")

endmodule

### hdl/icy_metadata_deframer_unit.sv
// An accepted byte is held in the input register, and its result in the output register.
// Throughput: one byte per cycle unless results stall; the output and input registers
//   decouple the two sides, so a stalled result blocks input only once both are full.
// Reset (synchronous, active high): empties both registers, returns to the audio
//   phase with all counters cleared, sets the interval to 0 and title extraction on.
module icy_metadata_deframer_unit import icy_mdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  icy_mdf_cfg_if.sink        cfg,
  icy_mdf_byte_if.sink       stream,
  icy_mdf_result_if.source   result
);

  cfg_t       regs;
  res_t       res;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  kind_t      out_kind;
  logic [7:0] out_byte;
  logic       advance;

  icy_mdf_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  icy_mdf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .cfg       (regs),
    .res       (res)
  );

  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  assign result.valid    = out_valid;
  assign result.kind     = out_kind;
  assign result.out_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stream.ready) begin
        in_valid <= stream.valid;
      end
      if (advance && res.hit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
    end
    if (advance && res.hit) begin
      out_kind <= res.kind;
      out_byte <= res.data;
    end
  end

endmodule
